// ----- src/slot_table_with_compaction_macros.svh -----
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shared concurrent assertion forms for the slot table checker.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_WITH_COMPACTION_MACROS_SVH
`define SLOT_TABLE_WITH_COMPACTION_MACROS_SVH

// same-cycle implication
`define SLTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sltc_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot table package
// Operation and status codes, controller/datapath command and status types.
// ----------------------------------------------------------------------------
package sltc_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_PUSH    = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_POP     = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_COMPACT = 3'd6
  } op_e_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OCCUPIED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_SLOT_EMPTY  = 3'd3,
    ST_TABLE_EMPTY = 3'd4
  } status_e_t;

  typedef struct packed {
    logic      item_ld;
    logic      ptr_ld_zero;
    logic      ptr_ld_top;
    logic      ptr_inc;
    logic      ptr_dec;
    logic      dst_clr;
    logic      dst_inc;
    logic      ram_we;
    logic      wr_dst;
    logic      wr_move;
    logic      vld_set_ptr;
    logic      vld_clr_ptr;
    logic      vld_set_dst;
    logic      vld_clr_all;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      res_cap;
    logic      out_ld;
    status_e_t status;
  } cmd_t;

  typedef struct packed {
    logic rng;
    logic vld_ptr;
    logic ptr_last;
    logic ptr_zero;
  } stat_t;

endpackage

// ----- src/sltc_ram.sv -----
// ----------------------------------------------------------------------------
// Slot table RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sltc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sltc_dp.sv -----
// ----------------------------------------------------------------------------
// Slot table datapath
// Scan pointer, compaction destination, valid bits, count, entry RAM and
// the output register.
// ----------------------------------------------------------------------------
module sltc_dp #(
  parameter int SLOTS      = 8,
  parameter int ENTRY_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sltc_pkg::cmd_t  cmd,
  output sltc_pkg::stat_t st,
  input  logic [2:0]      in_slot_index,
  input  logic [15:0]     in_entry_value,
  output logic [15:0]     out_entry_out,
  output logic [2:0]      out_status,
  output logic [3:0]      out_occupied_count,
  output logic            out_is_empty
);
  import sltc_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = (ENTRY_BITS < 16) ? ENTRY_BITS : 16;

  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [IW-1:0]    dst_r, dst_nxt;
  logic [SLOTS-1:0] vld_r, vld_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             rng_r;
  logic [EW-1:0]    val_r;
  logic [EW-1:0]    res_r;
  logic [EW-1:0]    rdata;
  logic [EW-1:0]    wdata;
  logic [IW-1:0]    waddr;
  logic [15:0]      o_entry_r;
  status_e_t        o_status_r;
  logic [3:0]       o_count_r;
  logic             o_empty_r;

  assign waddr = cmd.wr_dst ? dst_r : ptr_r;
  assign wdata = cmd.wr_move ? rdata : val_r;

  sltc_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  always_comb begin
    ptr_nxt = ptr_r;
    priority if (cmd.item_ld) begin
      ptr_nxt = IW'(in_slot_index);
    end else if (cmd.ptr_ld_zero) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_ld_top) begin
      ptr_nxt = IW'(SLOTS - 1);
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_r - 1'b1;
    end

    dst_nxt = dst_r;
    priority if (cmd.dst_clr) begin
      dst_nxt = '0;
    end else if (cmd.dst_inc) begin
      dst_nxt = dst_r + 1'b1;
    end

    vld_nxt = vld_r;
    if (cmd.vld_clr_all) begin
      vld_nxt = '0;
    end
    if (cmd.vld_clr_ptr) begin
      vld_nxt[ptr_r] = 1'b0;
    end
    if (cmd.vld_set_ptr) begin
      vld_nxt[ptr_r] = 1'b1;
    end
    if (cmd.vld_set_dst) begin
      vld_nxt[dst_r] = 1'b1;
    end

    cnt_nxt = cnt_r;
    priority if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    dst_r <= dst_nxt;
    if (cmd.item_ld) begin
      rng_r <= int'(in_slot_index) < SLOTS;
      val_r <= in_entry_value[EW-1:0];
      res_r <= '0;
    end else if (cmd.res_cap) begin
      res_r <= rdata;
    end
    if (cmd.out_ld) begin
      o_entry_r  <= 16'(res_r);
      o_status_r <= cmd.status;
      o_count_r  <= 4'(cnt_r);
      o_empty_r  <= (cnt_r == '0);
    end
  end

  assign st.rng      = rng_r;
  assign st.vld_ptr  = vld_r[ptr_r];
  assign st.ptr_last = (ptr_r == IW'(SLOTS - 1));
  assign st.ptr_zero = (ptr_r == '0);

  assign out_entry_out      = o_entry_r;
  assign out_status         = o_status_r;
  assign out_occupied_count = o_count_r;
  assign out_is_empty       = o_empty_r;

endmodule

// ----- src/sltc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot table controller
// Sequences each operation over the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module sltc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_operation,
  output logic            out_valid,
  input  logic            out_stall,
  input  sltc_pkg::stat_t st,
  output sltc_pkg::cmd_t  cmd
);
  import sltc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_POP,
    S_RDWAIT,
    S_CMP_RD,
    S_CMP_WR,
    S_FINISH
  } state_t;

  state_t    state_r, state_nxt;
  op_e_t     op_r, op_nxt;
  status_e_t sts_r, sts_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.status    = sts_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          op_nxt      = op_e_t'(in_operation);
          sts_nxt     = ST_OK;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (op_r)
          OP_INSERT: begin
            if (!st.rng || st.vld_ptr) begin
              sts_nxt = ST_OCCUPIED;
            end else begin
              cmd.ram_we      = 1'b1;
              cmd.vld_set_ptr = 1'b1;
              cmd.cnt_inc     = 1'b1;
            end
          end
          OP_PUSH: begin
            cmd.ptr_ld_zero = 1'b1;
            state_nxt       = S_PUSH;
          end
          OP_REMOVE: begin
            if (!st.rng || !st.vld_ptr) begin
              sts_nxt = ST_SLOT_EMPTY;
            end else begin
              cmd.vld_clr_ptr = 1'b1;
              cmd.cnt_dec     = 1'b1;
              state_nxt       = S_RDWAIT;
            end
          end
          OP_POP: begin
            cmd.ptr_ld_top = 1'b1;
            state_nxt      = S_POP;
          end
          OP_READ: begin
            if (!st.rng || !st.vld_ptr) begin
              sts_nxt = ST_SLOT_EMPTY;
            end else begin
              state_nxt = S_RDWAIT;
            end
          end
          OP_CLEAR: begin
            cmd.vld_clr_all = 1'b1;
            cmd.cnt_clr     = 1'b1;
          end
          OP_COMPACT: begin
            cmd.ptr_ld_zero = 1'b1;
            cmd.dst_clr     = 1'b1;
            state_nxt       = S_CMP_RD;
          end
          default: begin
          end
        endcase
      end
      S_PUSH: begin
        priority if (!st.vld_ptr) begin
          cmd.ram_we      = 1'b1;
          cmd.vld_set_ptr = 1'b1;
          cmd.cnt_inc     = 1'b1;
          state_nxt       = S_FINISH;
        end else if (st.ptr_last) begin
          sts_nxt   = ST_FULL;
          state_nxt = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_POP: begin
        priority if (st.vld_ptr) begin
          cmd.vld_clr_ptr = 1'b1;
          cmd.cnt_dec     = 1'b1;
          state_nxt       = S_RDWAIT;
        end else if (st.ptr_zero) begin
          sts_nxt   = ST_TABLE_EMPTY;
          state_nxt = S_FINISH;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.res_cap = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_CMP_RD: begin
        priority if (st.vld_ptr) begin
          state_nxt = S_CMP_WR;
        end else if (st.ptr_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_CMP_WR: begin
        // move entry down; set at dst wins when dst equals src
        cmd.ram_we      = 1'b1;
        cmd.wr_dst      = 1'b1;
        cmd.wr_move     = 1'b1;
        cmd.vld_clr_ptr = 1'b1;
        cmd.vld_set_dst = 1'b1;
        cmd.dst_inc     = 1'b1;
        if (st.ptr_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_CMP_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= OP_INSERT;
      sts_r       <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      sts_r       <= sts_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/slot_table_with_compaction.sv -----
// ----------------------------------------------------------------------------
// Slot table with compaction
// Table of SLOTS entries with valid bits and an occupancy count; insert,
// push to lowest free slot, remove, pop highest occupied slot, read, clear, compact.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall): in_operation, in_slot_index,
//   in_entry_value. Output beat (out_valid/out_stall): out_entry_out,
//   out_status, out_occupied_count, out_is_empty. One output beat per
//   input beat, in order.
//   One operation is in flight at a time. Remove, read and a successful pop
//   add a wait for the registered RAM read; push, pop and compact scan
//   the slots, and compact also moves each occupied slot down. The scan
//   pointer walks one slot per cycle, pausing for the move at each
//   occupied slot during compaction. The entry RAM has one registered
//   read port.
//   The next beat is taken once the result sits in the output register,
//   even while the receiver stalls; a second result then waits for it.
//   Reset clears the valid bits, the count and out_valid; entry RAM
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module slot_table_with_compaction #(
  parameter int SLOTS      = 8,
  parameter int ENTRY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_slot_index,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_entry_out,
  output logic [2:0]  out_status,
  output logic [3:0]  out_occupied_count,
  output logic        out_is_empty
);
  import sltc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sltc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .st           (st),
    .cmd          (cmd)
  );

  sltc_dp #(
    .SLOTS      (SLOTS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_slot_index      (in_slot_index),
    .in_entry_value     (in_entry_value),
    .out_entry_out      (out_entry_out),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count),
    .out_is_empty       (out_is_empty)
  );

endmodule

// ----- src/sltc_chk.sv -----
// ----------------------------------------------------------------------------
// Slot table checker
// Port-level assertions on the slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "slot_table_with_compaction_macros.svh"

module sltc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_operation,
  input logic [2:0]  in_slot_index,
  input logic [15:0] in_entry_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_entry_out,
  input logic [2:0]  out_status,
  input logic [3:0]  out_occupied_count,
  input logic        out_is_empty
);
  import sltc_pkg::*;

  `SLTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_entry_out) && $stable(out_status)
    && $stable(out_occupied_count) && $stable(out_is_empty),
    "stalled result beat changed")

  `SLTC_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
    "second beat accepted while an operation is in flight")

  `SLTC_ASSERT_NOW(a_err_zero, out_valid && (out_status != ST_OK), out_entry_out == 16'd0,
    "error result carries a nonzero entry")

  `SLTC_ASSERT_NOW(a_empty_count, out_valid && out_is_empty, out_occupied_count == 4'd0,
    "empty table reports a nonzero count")

  `SLTC_ASSERT_NOW(a_status_code, out_valid,
    (out_status == ST_OK) || (out_status == ST_OCCUPIED) || (out_status == ST_FULL)
    || (out_status == ST_SLOT_EMPTY) || (out_status == ST_TABLE_EMPTY),
    "undefined status code")

endmodule

bind slot_table_with_compaction sltc_chk u_chk (.*);
